// ----- rtl/core/sdt_pkg.sv -----
// Shared constants, types and microcode table for the scaled decimal text formatter.
`default_nettype none

package sdt_pkg;

  // Field widths fixed by the word formats.
  localparam int MANT_W  = 64;
  localparam int EXP_W   = 7;
  localparam int GROUP_W = 64;
  localparam int CNT_W   = 4;

  // Formatting limits.
  localparam int CHARS      = 8;
  localparam int EXP_LIMIT  = 63;
  localparam int NUM_DIGITS = 19;
  localparam int DIGIT_W    = $clog2(NUM_DIGITS);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int LEN_W      = 7;

  // The converter shifts two bits of the magnitude per step.
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STEPS    = MANT_W / BITS_PER_STEP;
  localparam int LOOP_W        = $clog2(CONV_STEPS);

  // ASCII characters used in the text.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Datapath action selected by a microcode word.
  typedef enum logic [1:0] {
    ACT_LOAD,
    ACT_CONV,
    ACT_SIZE,
    ACT_EMIT
  } act_t;

  // Branch condition of a microcode word.
  typedef enum logic [1:0] {
    COND_NEXT,
    COND_LOOP,
    COND_MORE
  } cond_t;

  // Placement of the decimal point in the text.
  typedef enum logic [1:0] {
    MODE_INT,
    MODE_LEAD,
    MODE_POINT
  } mode_t;

  typedef logic [1:0] step_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic take;
    logic load;
    logic conv;
    logic size;
    logic emit;
  } ctrl_t;

  // Conditions from the datapath and channels back to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic more;
  } status_t;

  localparam step_t STEP_LOAD = 2'd0;
  localparam step_t STEP_CONV = 2'd1;
  localparam step_t STEP_SIZE = 2'd2;
  localparam step_t STEP_EMIT = 2'd3;

  // Microcode program. The emit step is the last one, so falling through it
  // wraps the step counter back to the load step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      STEP_LOAD: w = '{act: ACT_LOAD, cond: COND_NEXT, target: STEP_LOAD};
      STEP_CONV: w = '{act: ACT_CONV, cond: COND_LOOP, target: STEP_CONV};
      STEP_SIZE: w = '{act: ACT_SIZE, cond: COND_NEXT, target: STEP_SIZE};
      STEP_EMIT: w = '{act: ACT_EMIT, cond: COND_MORE, target: STEP_EMIT};
      default:   w = '{act: ACT_LOAD, cond: COND_NEXT, target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sdt_if.sv -----
// Valid/ready channel interfaces for numbers in and text groups out.
`default_nettype none

interface sdt_in_if;
  import sdt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [MANT_W-1:0] mantissa;
  logic signed [EXP_W-1:0]  exponent;

  modport source(output valid, output mantissa, output exponent, input ready);
  modport sink(input valid, input mantissa, input exponent, output ready);
endinterface

interface sdt_out_if;
  import sdt_pkg::*;
  logic               valid;
  logic               ready;
  logic [GROUP_W-1:0] char_group;
  logic [CNT_W-1:0]   char_count;
  logic               last_group;

  modport source(output valid, output char_group, output char_count, output last_group,
                 input ready);
  modport sink(input valid, input char_group, input char_count, input last_group,
               output ready);
endinterface

`default_nettype wire

// ----- rtl/core/scaled_decimal_to_text_top.sv -----
// Top level of the scaled decimal text formatter.
`default_nettype none

// Formats mantissa * 10^exponent as exact ASCII decimal text, up to eight
// characters per output word, first character in the low byte, with a count
// and a last flag. A number passes through a take step, the conversion loop of
// the binary to BCD converter (two magnitude bits per step), a sizing step and
// then one emit step per output word, 1 to 11 words; an emit step waits while
// the output register is stalled. The next number is taken as soon as the last
// word of the previous one sits in the output register. Exponents of -64 are
// treated as -63.
module scaled_decimal_to_text_top
  import sdt_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  sdt_in_if.sink    number,
  sdt_out_if.source text
);

  ctrl_t                       ctrl;
  status_t                     status;
  logic [NUM_DIGITS-1:0][3:0]  digits;
  logic                        neg;
  logic signed [EXP_W-1:0]     exp_sat;
  logic                        more;
  logic                        out_free;

  assign status = '{in_valid: number.valid, out_free: out_free, more: more};
  assign number.ready = ctrl.take;

  // Microcode sequencer.
  sdt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Binary to BCD conversion.
  sdt_bcd u_bcd (
    .clk      (clk),
    .ctrl     (ctrl),
    .mantissa (number.mantissa),
    .exponent (number.exponent),
    .digits   (digits),
    .neg      (neg),
    .exp_sat  (exp_sat)
  );

  // Text layout and output words.
  sdt_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .digits    (digits),
    .neg       (neg),
    .exp_sat   (exp_sat),
    .out_ready (text.ready),
    .more      (more),
    .out_free  (out_free),
    .out_valid (text.valid),
    .out_group (text.char_group),
    .out_count (text.char_count),
    .out_last  (text.last_group)
  );

endmodule

`default_nettype wire

// ----- rtl/core/sdt_seq.sv -----
// Microcode sequencer: step counter, loop counter and branch logic.
`default_nettype none

module sdt_seq
  import sdt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t status,
  output ctrl_t        ctrl
);

  step_t             step;
  step_t             step_next;
  logic [LOOP_W-1:0] loop_cnt;
  logic [LOOP_W-1:0] loop_cnt_next;
  uword_t            uw;
  logic              fire;
  logic              jump;

  assign uw = ucode(step);

  // An action fires when its channel side can move; otherwise the step holds.
  always_comb begin
    case (uw.act)
      ACT_LOAD: fire = status.in_valid;
      ACT_EMIT: fire = status.out_free;
      default:  fire = 1'b1;
    endcase

    case (uw.cond)
      COND_LOOP: jump = (loop_cnt != '0);
      COND_MORE: jump = status.more;
      default:   jump = 1'b0;
    endcase

    if (!fire) begin
      step_next = step;
    end else if (jump) begin
      step_next = uw.target;
    end else begin
      step_next = step + 2'd1;
    end

    loop_cnt_next = loop_cnt;
    if (fire && uw.act == ACT_LOAD) begin
      loop_cnt_next = LOOP_W'(CONV_STEPS - 1);
    end else if (uw.act == ACT_CONV) begin
      loop_cnt_next = loop_cnt - 1'b1;
    end

    ctrl.take = (uw.act == ACT_LOAD);
    ctrl.load = fire && (uw.act == ACT_LOAD);
    ctrl.conv = (uw.act == ACT_CONV);
    ctrl.size = (uw.act == ACT_SIZE);
    ctrl.emit = fire && (uw.act == ACT_EMIT);
  end

  // Step and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= STEP_LOAD;
      loop_cnt <= '0;
    end else begin
      step     <= step_next;
      loop_cnt <= loop_cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sdt_bcd.sv -----
// Magnitude capture and shift-and-add-3 binary to BCD converter.
`default_nettype none

module sdt_bcd
  import sdt_pkg::*;
(
  input  wire logic                    clk,
  input  wire ctrl_t                   ctrl,
  input  wire logic signed [MANT_W-1:0] mantissa,
  input  wire logic signed [EXP_W-1:0]  exponent,
  output logic [NUM_DIGITS-1:0][3:0]    digits,
  output logic                          neg,
  output logic signed [EXP_W-1:0]       exp_sat
);

  logic [MANT_W-1:0] bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_half;
  logic [BCD_W-1:0]  bcd_next;
  logic signed [EXP_W-1:0] exp_clip;

  // One double-dabble step: correct every digit of five or more, then shift in a bit.
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] v, input logic b);
    logic [BCD_W-1:0] adj;
    logic [3:0]       d;
    adj = v;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (d >= 4'd5) begin
        adj[4*i +: 4] = d + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // Two magnitude bits enter the BCD register per step.
  always_comb begin
    bcd_half = dabble(bcd, bin[MANT_W-1]);
    bcd_next = dabble(bcd_half, bin[MANT_W-2]);
  end

  // Out-of-range exponents saturate to the limit.
  always_comb begin
    if (exponent < -EXP_LIMIT) begin
      exp_clip = EXP_W'(-EXP_LIMIT);
    end else if (exponent > EXP_LIMIT) begin
      exp_clip = EXP_W'(EXP_LIMIT);
    end else begin
      exp_clip = exponent;
    end
  end

  // The most negative mantissa negates to its exact unsigned magnitude.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg     <= mantissa[MANT_W-1];
      bin     <= mantissa[MANT_W-1] ? (~mantissa + MANT_W'(1)) : mantissa;
      bcd     <= '0;
      exp_sat <= exp_clip;
    end else if (ctrl.conv) begin
      bin <= {bin[MANT_W-BITS_PER_STEP-1:0], BITS_PER_STEP'(0)};
      bcd <= bcd_next;
    end
  end

  assign digits = bcd;

endmodule

`default_nettype wire

// ----- rtl/core/sdt_pack.sv -----
// Text layout, group packing and the output register.
`default_nettype none

module sdt_pack
  import sdt_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ctrl_t                       ctrl,
  input  wire logic [NUM_DIGITS-1:0][3:0]  digits,
  input  wire logic                        neg,
  input  wire logic signed [EXP_W-1:0]     exp_sat,
  input  wire logic                        out_ready,
  output logic                             more,
  output logic                             out_free,
  output logic                             out_valid,
  output logic [GROUP_W-1:0]               out_group,
  output logic [CNT_W-1:0]                 out_count,
  output logic                             out_last
);

  logic [DIGIT_W-1:0] nd;
  logic [DIGIT_W-1:0] nd_next;
  mode_t              mode;
  mode_t              mode_next;
  logic [LEN_W-1:0]   pos;
  logic [LEN_W-1:0]   pos_next;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_next;
  logic [LEN_W-1:0]   base;
  logic signed [LEN_W:0] point;
  logic [LEN_W:0]     remain;
  logic [CNT_W-1:0]   count;
  logic [GROUP_W-1:0] group;

  // Character for a digit counted from the most significant one.
  function automatic logic [7:0] dig_char(input logic [NUM_DIGITS-1:0][3:0] dv,
                                          input logic [DIGIT_W-1:0] n,
                                          input logic [LEN_W:0] q);
    logic [LEN_W:0] idx;
    idx = (LEN_W+1)'(n) - (LEN_W+1)'(1) - q;
    if (idx < (LEN_W+1)'(NUM_DIGITS)) begin
      return CH_ZERO | {4'd0, dv[idx[DIGIT_W-1:0]]};
    end
    return CH_ZERO;
  endfunction

  // Character at position j of the whole text.
  function automatic logic [7:0] char_at(input logic [LEN_W:0] j,
                                         input logic s,
                                         input mode_t m,
                                         input logic [DIGIT_W-1:0] n,
                                         input logic [LEN_W-1:0] ps,
                                         input logic [NUM_DIGITS-1:0][3:0] dv);
    logic [LEN_W:0] p;
    logic [LEN_W:0] pw;
    logic [7:0]     c;
    p  = j - (LEN_W+1)'(s);
    pw = (LEN_W+1)'(ps);
    if (j < (LEN_W+1)'(s)) begin
      c = CH_MINUS;
    end else begin
      case (m)
        MODE_INT: begin
          c = (p < (LEN_W+1)'(n)) ? dig_char(dv, n, p) : CH_ZERO;
        end
        MODE_LEAD: begin
          if (p == (LEN_W+1)'(1)) begin
            c = CH_POINT;
          end else if (p < pw) begin
            c = CH_ZERO;
          end else begin
            c = dig_char(dv, n, p - pw);
          end
        end
        MODE_POINT: begin
          if (p < pw) begin
            c = dig_char(dv, n, p);
          end else if (p == pw) begin
            c = CH_POINT;
          end else begin
            c = dig_char(dv, n, p - (LEN_W+1)'(1));
          end
        end
        default: c = CH_ZERO;
      endcase
    end
    return c;
  endfunction

  // Digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    nd_next = DIGIT_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        nd_next = DIGIT_W'(i + 1);
      end
    end
  end

  // Point placement and text length.
  always_comb begin
    point = (LEN_W+1)'(nd_next) + (LEN_W+1)'(exp_sat);
    if (!exp_sat[EXP_W-1]) begin
      mode_next = MODE_INT;
      pos_next  = '0;
      len_next  = LEN_W'((LEN_W+1)'(neg) + (LEN_W+1)'(nd_next) + (LEN_W+1)'(exp_sat));
    end else if (point[LEN_W] || point == '0) begin
      mode_next = MODE_LEAD;
      pos_next  = LEN_W'((LEN_W+1)'(2) - point);
      len_next  = LEN_W'((LEN_W+1)'(neg) + (LEN_W+1)'(2) - (LEN_W+1)'(exp_sat));
    end else begin
      mode_next = MODE_POINT;
      pos_next  = point[LEN_W-1:0];
      len_next  = LEN_W'((LEN_W+1)'(neg) + (LEN_W+1)'(nd_next) + (LEN_W+1)'(1));
    end
  end

  // Group at the current base: up to eight characters, unused bytes zero.
  always_comb begin
    remain = (LEN_W+1)'(len) - (LEN_W+1)'(base);
    more   = (remain > (LEN_W+1)'(CHARS));
    count  = more ? CNT_W'(CHARS) : remain[CNT_W-1:0];
    group  = '0;
    for (int i = 0; i < CHARS; i++) begin
      if (CNT_W'(i) < count) begin
        group[8*i +: 8] = char_at((LEN_W+1)'(base) + (LEN_W+1)'(i), neg, mode, nd, pos,
                                  digits);
      end
    end
  end

  assign out_free = !out_valid || out_ready;

  // Layout registers, set by the sizing step and walked by the emit step.
  always_ff @(posedge clk) begin
    if (ctrl.size) begin
      nd   <= nd_next;
      mode <= mode_next;
      pos  <= pos_next;
      len  <= len_next;
      base <= '0;
    end else if (ctrl.emit) begin
      base <= base + LEN_W'(CHARS);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_group <= group;
      out_count <= count;
      out_last  <= !more;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sdt_checker.sv -----
// Port-level assertions for the scaled decimal text formatter, bound to the top level.
`default_nettype none

module sdt_checker
  import sdt_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CNT_W-1:0] out_count,
  input wire logic             out_last
);

  // A stalled output word keeps its count and last flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_last))
    else $error("stalled output word changed");

  // Every word carries between one and eight characters.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_count != '0) && (out_count <= CNT_W'(CHARS)))
    else $error("character count out of range");

  // Only the final word of a number may be partly filled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_count == CNT_W'(CHARS))
    else $error("short word before the last one");

  // After taking a number the block is busy converting it.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("number taken while converting");

endmodule

bind scaled_decimal_to_text_top sdt_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (number.valid),
  .in_ready  (number.ready),
  .out_valid (text.valid),
  .out_ready (text.ready),
  .out_count (text.char_count),
  .out_last  (text.last_group)
);

`default_nettype wire
